### design/fftq_pkg.sv
// package for the radix-2 q1.31 fft block: sizes, twiddle rom, state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fftq_pkg;
   localparam int FFT_SIZE  = 64;
   localparam int STAGES    = $clog2(FFT_SIZE);
   localparam int IDX_W     = (STAGES < 1) ? 1 : STAGES;
   localparam int TW_DEPTH  = (FFT_SIZE / 2 < 1) ? 1 : FFT_SIZE / 2;
   localparam int TW_W      = (TW_DEPTH > 1) ? $clog2(TW_DEPTH) : 1;
   localparam int ROM_STEP  = 64 / FFT_SIZE;
   localparam int STG_W     = $clog2(STAGES + 1);
   // register stages inside the butterfly
   localparam int BF_LAT    = 2;

   typedef enum logic [1:0] {
      ST_LOAD, ST_BFLY, ST_EMIT
   } fsm_state_type;

   typedef struct packed {
      logic [31:0] cos_w;
      logic [31:0] sin_w;
   } twiddle_type;

   function automatic logic [31:0] quarter_wave(input logic [4:0] m);
      logic [31:0] v;
      begin
         case (m)
            5'd0:  v = 32'd2147483647;
            5'd1:  v = 32'd2137142927;
            5'd2:  v = 32'd2106220352;
            5'd3:  v = 32'd2055013723;
            5'd4:  v = 32'd1984016189;
            5'd5:  v = 32'd1893911494;
            5'd6:  v = 32'd1785567396;
            5'd7:  v = 32'd1660027308;
            5'd8:  v = 32'd1518500250;
            5'd9:  v = 32'd1362349204;
            5'd10: v = 32'd1193077991;
            5'd11: v = 32'd1012316784;
            5'd12: v = 32'd821806413;
            5'd13: v = 32'd623381598;
            5'd14: v = 32'd418953276;
            5'd15: v = 32'd210490206;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

   // twiddle for table index k: cos and sin of 2*pi*k/N
   function automatic twiddle_type twiddle(input logic [TW_W-1:0] k);
      twiddle_type t;
      logic [4:0]  m;
      begin
         m = 5'((32'(k) * ROM_STEP) & 32'd31);
         if (m <= 5'd16) begin
            t.cos_w = quarter_wave(m);
            t.sin_w = quarter_wave(5'(5'd16 - m));
         end else begin
            t.cos_w = 32'd0 - quarter_wave(5'(6'd32 - 6'(m)));
            t.sin_w = quarter_wave(5'(m - 5'd16));
         end
         return t;
      end
   endfunction

   function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] v);
      logic [IDX_W-1:0] r;
      begin
         for (int i = 0; i < IDX_W; i++) r[i] = v[IDX_W-1-i];
         return r;
      end
   endfunction
endpackage
`default_nettype wire

### design/fftq_cell.sv
// one cell of a chain: holds one complex value, passes it to its neighbor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module fftq_cell (
   input  wire logic        clock,
   input  wire logic        shift_en,
   input  wire logic        load_en,
   input  wire logic [31:0] load_re,
   input  wire logic [31:0] load_im,
   input  wire logic [31:0] prev_re,
   input  wire logic [31:0] prev_im,
   output logic      [31:0] re_ff,
   output logic      [31:0] im_ff
);
   logic [31:0] re_in, im_in;
   always_comb begin
      re_in = re_ff;
      im_in = im_ff;
      // a direct write wins over the neighbor hand-off
      if (load_en) begin
         re_in = load_re;
         im_in = load_im;
      end else if (shift_en) begin
         re_in = prev_re;
         im_in = prev_im;
      end
   end
   always_ff @(posedge clock) begin
      re_ff <= re_in;
      im_ff <= im_in;
   end
endmodule
`default_nettype wire

### design/fftq_bfly.sv
// pipelined radix-2 butterfly: complex twiddle multiply, then add and subtract
// depends on fftq_pkg
`timescale 1ns / 1ps
`default_nettype none
module fftq_bfly import fftq_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] top_re,
   input  wire logic [31:0] top_im,
   input  wire logic [31:0] bot_re,
   input  wire logic [31:0] bot_im,
   input  wire twiddle_type tw,
   output logic      [31:0] sum_re_ff,
   output logic      [31:0] sum_im_ff,
   output logic      [31:0] dif_re_ff,
   output logic      [31:0] dif_im_ff
);
   logic signed [63:0] p_cr_ff, p_si_ff, p_ci_ff, p_sr_ff;
   logic [31:0] a_re_ff, a_im_ff;
   logic signed [63:0] t_re_w, t_im_w;
   logic [31:0] t_re, t_im;

   // stage one: four products
   always_ff @(posedge clock) begin
      p_cr_ff <= $signed(tw.cos_w) * $signed(bot_re);
      p_si_ff <= $signed(tw.sin_w) * $signed(bot_im);
      p_ci_ff <= $signed(tw.cos_w) * $signed(bot_im);
      p_sr_ff <= $signed(tw.sin_w) * $signed(bot_re);
      a_re_ff <= top_re;
      a_im_ff <= top_im;
   end

   always_comb begin
      t_re_w = p_cr_ff + p_si_ff;
      t_im_w = p_ci_ff - p_sr_ff;
      t_re   = t_re_w[62:31];
      t_im   = t_im_w[62:31];
   end

   // stage two: sum and difference, wrapping
   always_ff @(posedge clock) begin
      sum_re_ff <= a_re_ff + t_re;
      sum_im_ff <= a_im_ff + t_im;
      dif_re_ff <= a_re_ff - t_re;
      dif_im_ff <= a_im_ff - t_im;
   end
endmodule
`default_nettype wire

### design/fft_radix2_q31_block_scaled.sv
// top level of the streaming radix-2 dit fft with block scaling
// depends on fftq_pkg, fftq_cell, fftq_bfly
//
//  channel | direction | ports                                      | carries
//  req     | in        | req_valid req_ready req_sample_real/imag   | one sample
//  rsp     | out       | rsp_valid rsp_ready rsp_bin_* rsp_final_bin | one bin
//
// a frame loads at up to one sample per cycle, each sample written straight
// into the ring cell of its bit-reversed index
// each of the log2N stages rotates the ring once through the butterfly,
// then lets the butterfly pipe drain before the next stage
// then N bins leave, one per accepted transaction; a stalled rsp holds the ring
// reset is synchronous, active high, and returns to loading an empty frame
`timescale 1ns / 1ps
`default_nettype none
module fft_radix2_q31_block_scaled import fftq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_sample_real,
   input  wire logic [31:0] req_sample_imag,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_bin_real,
   output logic      [31:0] rsp_bin_imag,
   output logic      [5:0]  rsp_bin_number,
   output logic             rsp_final_bin,
   output logic      [2:0]  rsp_scale_shifts
);
   // the ring: cell 0 is the head, data moves from cell i+1 to cell i,
   // the tail (cell N-1) takes what enters the ring
   logic [31:0] c_re [FFT_SIZE];
   logic [31:0] c_im [FFT_SIZE];
   logic [31:0] feed_re, feed_im;
   logic        shift_en, load_en;
   logic [IDX_W-1:0] load_sel;

   // delay chain for butterfly differences, waiting for their bottom slot
   logic [31:0] dl_re [TW_DEPTH];
   logic [31:0] dl_im [TW_DEPTH];

   fsm_state_type state_ff, state_in;
   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic [STG_W-1:0] stg_ff, stg_in;
   logic [IDX_W-1:0] q;
   logic [IDX_W-1:0] half_w;
   logic [TW_W-1:0]  twk;
   twiddle_type      tw;
   logic [31:0] top_re, top_im, bot_re, bot_im;
   logic [31:0] s_re, s_im, x_re, x_im;

   genvar g;
   generate
      for (g = 0; g < FFT_SIZE; g++) begin : g_cell
         if (g == FFT_SIZE - 1) begin : g_tail
            fftq_cell u_cell (.clock, .shift_en,
               .load_en(load_en && (load_sel == IDX_W'(g))),
               .load_re(req_sample_real), .load_im(req_sample_imag),
               .prev_re(feed_re), .prev_im(feed_im),
               .re_ff(c_re[g]), .im_ff(c_im[g]));
         end else begin : g_body
            fftq_cell u_cell (.clock, .shift_en,
               .load_en(load_en && (load_sel == IDX_W'(g))),
               .load_re(req_sample_real), .load_im(req_sample_imag),
               .prev_re(c_re[g+1]), .prev_im(c_im[g+1]),
               .re_ff(c_re[g]), .im_ff(c_im[g]));
         end
      end
      for (g = 0; g < TW_DEPTH; g++) begin : g_dly
         if (g == 0) begin : g_first
            fftq_cell u_cell (.clock, .shift_en(1'b1), .load_en(1'b0),
               .load_re(32'd0), .load_im(32'd0),
               .prev_re(x_re), .prev_im(x_im),
               .re_ff(dl_re[g]), .im_ff(dl_im[g]));
         end else begin : g_next
            fftq_cell u_cell (.clock, .shift_en(1'b1), .load_en(1'b0),
               .load_re(32'd0), .load_im(32'd0),
               .prev_re(dl_re[g-1]), .prev_im(dl_im[g-1]),
               .re_ff(dl_re[g]), .im_ff(dl_im[g]));
         end
      end
   endgenerate

   // head (index cnt) is the top, its partner sits half cells further on;
   // both are halved on the way in, which is the block scaling of the stage
   always_comb begin
      half_w = IDX_W'(1) << stg_ff;
      twk    = TW_W'((cnt_ff[IDX_W-1:0] & (half_w - 1'b1))
                     << (STG_W'(STAGES - 1) - stg_ff));
      tw     = twiddle(twk);
      top_re = {c_re[0][31], c_re[0][31:1]};
      top_im = {c_im[0][31], c_im[0][31:1]};
      bot_re = {c_re[half_w][31], c_re[half_w][31:1]};
      bot_im = {c_im[half_w][31], c_im[half_w][31:1]};
      // index of the value that the butterfly pipe delivers this cycle
      q      = IDX_W'(cnt_ff - (IDX_W+1)'(BF_LAT));
   end

   fftq_bfly u_bfly (
      .clock,
      .top_re, .top_im,
      .bot_re, .bot_im,
      .tw,
      .sum_re_ff(s_re), .sum_im_ff(s_im),
      .dif_re_ff(x_re), .dif_im_ff(x_im)
   );

   // what enters the tail each cycle
   always_comb begin
      feed_re = c_re[0];
      feed_im = c_im[0];
      if (state_ff == ST_BFLY && cnt_ff >= (IDX_W+1)'(BF_LAT)) begin
         if ((q & half_w) == '0) begin
            // top slot: the sum comes straight out of the pipe
            feed_re = s_re;
            feed_im = s_im;
         end else begin
            // bottom slot: the difference of its top partner, from the delay chain
            feed_re = dl_re[TW_W'(half_w - 1'b1)];
            feed_im = dl_im[TW_W'(half_w - 1'b1)];
         end
      end
   end

   // state machine
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      stg_in    = stg_ff;
      shift_en  = 1'b0;
      load_en   = 1'b0;
      load_sel  = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               load_en  = 1'b1;
               load_sel = bit_rev(cnt_ff[IDX_W-1:0]);
               if (cnt_ff == (IDX_W+1)'(FFT_SIZE - 1)) begin
                  cnt_in   = '0;
                  stg_in   = '0;
                  state_in = ST_BFLY;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_BFLY: begin
            // one rotation plus the pipe drain per stage
            shift_en = 1'b1;
            if (cnt_ff == (IDX_W+1)'(FFT_SIZE - 1 + BF_LAT)) begin
               cnt_in = '0;
               if (stg_ff == STG_W'(STAGES - 1)) begin
                  state_in = ST_EMIT;
               end else begin
                  stg_in = stg_ff + 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               shift_en = 1'b1;
               if (cnt_ff == (IDX_W+1)'(FFT_SIZE - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         stg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         stg_ff   <= stg_in;
      end
   end

   assign rsp_bin_real     = c_re[0];
   assign rsp_bin_imag     = c_im[0];
   assign rsp_bin_number   = 6'(cnt_ff);
   assign rsp_final_bin    = (cnt_ff == (IDX_W+1)'(FFT_SIZE - 1));
   assign rsp_scale_shifts = 3'(STAGES);

   // never take a sample while bins are pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req and rsp open together");
   // a frame ends in the transform
   a_load_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && req_valid && cnt_ff == (IDX_W+1)'(FFT_SIZE - 1))
      |=> state_ff == ST_BFLY) else $error("load did not close frame");
   // bin counter advances only on an accepted transaction
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(cnt_ff)) else $error("bin moved");
   // a waiting bin keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_bin_real)
      && $stable(rsp_bin_imag)) else $error("bin payload changed");
endmodule
`default_nettype wire
